### rtl/c2d_pkg.sv
// Shared constants, types and register codes for the 3x3 zero-padded convolution block.
`default_nettype none

package c2d_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int FILTER_TAPS = 3;

  localparam int DIM_W      = 11;
  localparam int COEF_ROW_W = 48;
  localparam int PIX_W      = 16;
  localparam int COEF_W     = 16;
  localparam int SUM_W      = 37;
  localparam int POS_W      = 10;
  localparam int CFG_IDX_W  = 3;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = COL_W + 1;

  localparam int TAP_OFF = 1 - FILTER_TAPS / 2;
  localparam int PROD_W  = PIX_W + 1 + COEF_W;
  localparam int GRP_W   = PROD_W + 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_TDATA_W = ((SUM_W + 2 * POS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - SUM_W - 2 * POS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_TOP     = 3'd2,
    REG_COEF_MID     = 3'd3,
    REG_COEF_BOT     = 3'd4
  } cfg_reg_t;

  // Clamped frame size plus a one-cycle restart strobe on a size write.
  typedef struct packed {
    logic [WCNT_W-1:0] width;
    logic [DIM_W-1:0]  height;
    logic              restart;
  } dims_t;

  // [row][col], row 0 on top, col 0 leftmost.
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  // Index 0 is the top filter row.
  typedef logic [2:0][COEF_ROW_W-1:0] coefs_t;

  typedef struct packed {
    window_t          win;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } work_t;

endpackage

`default_nettype wire

### rtl/conv2d_zero_padded_3x3.sv
// Top level of the streaming 3x3 zero-padded convolution block.
//
//  channel   dir  handshake                 payload
//  cfg       in   cfg_we                    cfg_index (register), cfg_data (value)
//  s_axis    in   s_axis_tvalid/tready      tdata: pixel_value; tuser: command
//  m_axis    out  m_axis_tvalid/tready      tdata: filtered_value, out_row, out_col;
//                                           tlast: frame_last
//
// One item per clock sustained while the output is not stalled. With nothing queued, a result
// passes from the edge that accepts the item completing it through the line-store read
// (ending with the queue write), then the product stage, the row-sum stage and the output
// register, whose valid drives m_axis_tvalid.
// Reset is synchronous and clears counters, queue and valids; the 1024x32 line store
// holds no reset state and needs no clearing pass.
// An output stall holds the back end; the front keeps taking beats until the queued
// windows plus the beat in the read stage reach four, then drops s_axis_tready.
// A write to image_width or image_height restarts the frame.
`default_nettype none

module conv2d_zero_padded_3x3 (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [c2d_pkg::COEF_ROW_W-1:0]       cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [c2d_pkg::PIX_W-1:0]            s_axis_tdata,   // [15:0] pixel_value
  input  logic                                 s_axis_tuser,   // [0] command
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [36:0] filtered_value, [46:37] out_row, [56:47] out_col, [63:57] zero
  output logic [c2d_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast    // frame_last
);
  import c2d_pkg::*;

  dims_t            dims;
  coefs_t           coefs;
  logic             push;
  work_t            push_data;
  logic             pop;
  work_t            head;
  logic             nonempty;
  logic [QCNT_W-1:0] q_count;
  logic [SUM_W-1:0] out_sum;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;

  c2d_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .dims  (dims),
    .coefs (coefs)
  );

  // Classify each beat, advance the window and hand finished windows on.
  c2d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .dims      (dims),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .cmd       (s_axis_tuser),
    .pix_in    (s_axis_tdata),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  c2d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .nonempty  (nonempty),
    .count     (q_count)
  );

  // Multiply and sum; the output register decouples m_axis from the queue.
  c2d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .coefs     (coefs),
    .head      (head),
    .nonempty  (nonempty),
    .pop       (pop),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_sum   (out_sum),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_col, out_row, out_sum};

endmodule

`default_nettype wire

### rtl/c2d_cfg.sv
// Configuration registers with size clamping and frame restart strobe.
`default_nettype none

module c2d_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]     index,
  input  logic [c2d_pkg::COEF_ROW_W-1:0]    data,
  output c2d_pkg::dims_t                    dims,
  output c2d_pkg::coefs_t                   coefs
);
  import c2d_pkg::*;

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  coefs_t           coef_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= DIM_W'(MAX_WIDTH);
      height_reg <= DIM_W'(MAX_HEIGHT);
      coef_reg   <= '0;
    end else if (we) begin
      case (cfg_reg_t'(index))
        REG_IMAGE_WIDTH:  width_reg   <= data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_reg  <= data[DIM_W-1:0];
        REG_COEF_TOP:     coef_reg[0] <= data;
        REG_COEF_MID:     coef_reg[1] <= data;
        REG_COEF_BOT:     coef_reg[2] <= data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (width_reg == '0) begin
      dims.width = WCNT_W'(1);
    end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
      dims.width = WCNT_W'(MAX_WIDTH);
    end else begin
      dims.width = WCNT_W'(width_reg);
    end
    if (height_reg == '0) begin
      dims.height = DIM_W'(1);
    end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
      dims.height = DIM_W'(MAX_HEIGHT);
    end else begin
      dims.height = height_reg;
    end
    dims.restart = we && ((cfg_reg_t'(index) == REG_IMAGE_WIDTH) ||
                          (cfg_reg_t'(index) == REG_IMAGE_HEIGHT));
  end

  assign coefs = coef_reg;

endmodule

`default_nettype wire

### rtl/c2d_front.sv
// Front end: position counters, line store and 3x3 window, one item per cycle while the queue has room.
`default_nettype none

module c2d_front (
  input  logic                           clk,
  input  logic                           rst,
  input  c2d_pkg::dims_t                 dims,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [c2d_pkg::PIX_W-1:0]      pix_in,
  input  logic [c2d_pkg::QCNT_W-1:0]     q_count,
  output logic                           push,
  output c2d_pkg::work_t                 push_data
);
  import c2d_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] pix;
    logic             gate_top;
    logic             gate_mid;
    logic             emit;
    logic             mode_a;
    logic             keep_c0;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } f1_t;

  logic [COL_W-1:0]   col;
  logic [DIM_W-1:0]   row;
  logic [COL_W-1:0]   col0;
  logic [DIM_W-1:0]   row0;
  logic [COL_W-1:0]   col_next;
  logic [DIM_W-1:0]   row_next;
  logic [WCNT_W-1:0]  col_inc;
  logic [DIM_W-1:0]   orow;
  logic [COL_W-1:0]   ocol;
  logic               restart_now;
  logic               accept;
  logic               emit_a;
  logic               emit_b;
  logic               last;
  f1_t                f1_in;
  f1_t                f1;
  logic               f1_valid;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_q;
  logic               byp;
  logic [2*PIX_W-1:0] byp_data;
  logic [2*PIX_W-1:0] rdata;
  logic [PIX_W-1:0]   top;
  logic [PIX_W-1:0]   mid;
  window_t            win;

  assign accept   = in_valid && in_ready;
  assign in_ready = (32'(q_count) + 32'(f1_valid)) < QUEUE_DEPTH;

  always_comb begin
    restart_now = ({1'b0, col} >= dims.width) || (32'(row) > 32'(dims.height) + 1);
    col0 = restart_now ? '0 : col;
    row0 = restart_now ? '0 : row;

    emit_a = (col0 == '0) && (row0 >= DIM_W'(2)) &&
             (32'(row0) < 32'(dims.height) + 2);
    emit_b = (col0 != '0) && (row0 >= DIM_W'(1)) &&
             (32'(row0) < 32'(dims.height) + 1);
    orow = emit_a ? row0 - DIM_W'(2) : row0 - DIM_W'(1);
    ocol = emit_a ? COL_W'(dims.width - WCNT_W'(1)) : col0 - COL_W'(1);
    last = (emit_a || emit_b) && (orow == dims.height - DIM_W'(1)) &&
           ({1'b0, ocol} == dims.width - WCNT_W'(1));

    col_inc = {1'b0, col0} + WCNT_W'(1);
    if (last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= dims.width) begin
      col_next = '0;
      row_next = row0 + DIM_W'(1);
    end else begin
      col_next = col_inc[COL_W-1:0];
      row_next = row0;
    end

    f1_in.addr     = col0;
    f1_in.pix      = (!cmd && (row0 < dims.height)) ? pix_in : '0;
    f1_in.gate_top = row0 >= DIM_W'(2);
    f1_in.gate_mid = row0 >= DIM_W'(1);
    f1_in.emit     = emit_a || emit_b;
    f1_in.mode_a   = emit_a;
    f1_in.keep_c0  = emit_a ? (dims.width >= WCNT_W'(2)) : (col0 != COL_W'(1));
    f1_in.row      = orow[POS_W-1:0];
    f1_in.col      = POS_W'(ocol);
    f1_in.last     = last;
  end

  // Counters and the stage that holds an item while its line data is read.
  always_ff @(posedge clk) begin
    if (rst || dims.restart) begin
      col      <= '0;
      row      <= '0;
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1 <= f1_in;
    end
  end

  // Line store: low half is the row two above, high half the row just above.
  always_ff @(posedge clk) begin
    if (f1_valid) begin
      line_mem[f1.addr] <= {f1.pix, mid};
    end
    if (accept) begin
      mem_q    <= line_mem[col0];
      byp      <= f1_valid && (f1.addr == col0);
      byp_data <= {f1.pix, mid};
    end
  end

  always_comb begin
    rdata = byp ? byp_data : mem_q;
    top   = f1.gate_top ? rdata[PIX_W-1:0] : '0;
    mid   = f1.gate_mid ? rdata[2*PIX_W-1:PIX_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (f1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= top;
      win[1][2] <= mid;
      win[2][2] <= f1.pix;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      push_data.win[r][0] = f1.keep_c0 ? win[r][1] : '0;
      push_data.win[r][1] = win[r][2];
    end
    push_data.win[0][2] = f1.mode_a ? '0 : top;
    push_data.win[1][2] = f1.mode_a ? '0 : mid;
    push_data.win[2][2] = f1.mode_a ? '0 : f1.pix;
    push_data.row  = f1.row;
    push_data.col  = f1.col;
    push_data.last = f1.last;
    push = f1_valid && f1.emit;
  end

endmodule

`default_nettype wire

### rtl/c2d_queue.sv
// Short FIFO of finished windows between the front end and the multiply back end.
`default_nettype none

module c2d_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  c2d_pkg::work_t              push_data,
  input  logic                        pop,
  output c2d_pkg::work_t              head,
  output logic                        nonempty,
  output logic [c2d_pkg::QCNT_W-1:0]  count
);
  import c2d_pkg::*;

  work_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign head     = slots[rd_ptr];
  assign nonempty = count != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/c2d_back.sv
// Back end: nine products, two adder stages and the output register.
`default_nettype none

module c2d_back (
  input  logic                        clk,
  input  logic                        rst,
  input  c2d_pkg::coefs_t             coefs,
  input  c2d_pkg::work_t              head,
  input  logic                        nonempty,
  output logic                        pop,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [c2d_pkg::SUM_W-1:0]   out_sum,
  output logic [c2d_pkg::POS_W-1:0]   out_row,
  output logic [c2d_pkg::POS_W-1:0]   out_col,
  output logic                        out_last
);
  import c2d_pkg::*;

  logic                     en;
  logic signed [PROD_W-1:0] prod_c [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [GRP_W-1:0]  grp_c  [3];
  logic signed [GRP_W-1:0]  grp_q  [3];
  logic signed [SUM_W-1:0]  sum_c;
  logic                     p_valid;
  logic                     g_valid;
  logic [POS_W-1:0]         p_row, g_row;
  logic [POS_W-1:0]         p_col, g_col;
  logic                     p_last, g_last;

  // Whole pipeline advances together unless the output beat is stalled.
  assign en  = !out_valid || out_ready;
  assign pop = en && nonempty;

  for (genvar r = 0; r < 3; r++) begin : g_row_taps
    for (genvar c = 0; c < 3; c++) begin : g_col_taps
      localparam int K = r - TAP_OFF;
      localparam int L = c - TAP_OFF;
      if (K >= 0 && K < FILTER_TAPS && L >= 0 && L < FILTER_TAPS) begin : g_tap
        logic signed [COEF_W-1:0] coef;
        assign coef = coefs[K][L*COEF_W +: COEF_W];
        assign prod_c[r][c] = $signed({1'b0, head.win[r][c]}) * coef;
      end else begin : g_no_tap
        assign prod_c[r][c] = '0;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      grp_c[r] = GRP_W'(prod_q[r][0]) + GRP_W'(prod_q[r][1]) + GRP_W'(prod_q[r][2]);
    end
    sum_c = SUM_W'(grp_q[0]) + SUM_W'(grp_q[1]) + SUM_W'(grp_q[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      g_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= nonempty;
      g_valid   <= p_valid;
      out_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q   <= prod_c;
      p_row    <= head.row;
      p_col    <= head.col;
      p_last   <= head.last;
      grp_q    <= grp_c;
      g_row    <= p_row;
      g_col    <= p_col;
      g_last   <= p_last;
      out_sum  <= sum_c;
      out_row  <= g_row;
      out_col  <= g_col;
      out_last <= g_last;
    end
  end

endmodule

`default_nettype wire

### rtl/c2d_checker.sv
// Port-level checks for the convolution top level, bound in by a bind statement.
`default_nettype none

module c2d_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [c2d_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input logic                                m_axis_tlast
);
  import c2d_pkg::*;

  localparam int ROW_LSB = SUM_W;
  localparam int COL_LSB = SUM_W + POS_W;

  // Set while the next result should open a frame at the origin.
  logic expect_origin;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_origin <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      expect_origin <= m_axis_tlast;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:COL_LSB+POS_W] == '0)
    else $error("output padding bits not zero");

  a_frame_origin: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && expect_origin |->
      m_axis_tdata[ROW_LSB +: POS_W] == '0 && m_axis_tdata[COL_LSB +: POS_W] == '0)
    else $error("first result of a frame is not at row 0, column 0");

endmodule

bind conv2d_zero_padded_3x3 c2d_checker u_c2d_checker (.*);

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the streaming 3x3 zero-padded convolution block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import c2d_pkg::*;

  localparam bit CMD_PIXEL = 1'b0;
  localparam bit CMD_FLUSH = 1'b1;
  // First register index past the defined ones; writes there must do nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_COEF_BOT + 1);

  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 300;
  localparam int LIMIT_NS      = 4_000_000;

  typedef struct {
    logic [SUM_W-1:0] value;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } pixel_result_t;

  // Tracks the block's frame state and holds the filtered pixels still due.
  class conv_scoreboard;
    bit [PIX_W-1:0]      line_mem [2*MAX_WIDTH];
    bit [PIX_W-1:0]      win_regs [9];
    bit [COEF_ROW_W-1:0] coef_rows [3];
    bit [DIM_W-1:0]      width_reg;
    bit [DIM_W-1:0]      height_reg;
    int unsigned         in_row;
    int unsigned         in_col;
    pixel_result_t       expected_pixels [$];
    int                  errors;

    function new();
      width_reg  = DIM_W'(MAX_WIDTH);
      height_reg = DIM_W'(MAX_HEIGHT);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function int unsigned clamp_dim(int unsigned raw, int unsigned top);
      if (raw < 1) return 1;
      if (raw > top) return top;
      return raw;
    endfunction

    function void restart_frame();
      in_row = 0;
      in_col = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_ROW_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH: begin
          width_reg = data[DIM_W-1:0];
          restart_frame();
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = data[DIM_W-1:0];
          restart_frame();
        end
        REG_COEF_TOP: coef_rows[0] = data;
        REG_COEF_MID: coef_rows[1] = data;
        REG_COEF_BOT: coef_rows[2] = data;
        default: ;
      endcase
    endfunction

    // Exact sum of pixel times signed coefficient over the window, kept to 37 bits.
    function logic [SUM_W-1:0] weighted_sum(bit [PIX_W-1:0] taps [9]);
      longint                   acc;
      longint                   px;
      logic signed [COEF_W-1:0] c;
      acc = 0;
      for (int k = 0; k < FILTER_TAPS; k++) begin
        for (int l = 0; l < FILTER_TAPS; l++) begin
          c   = coef_rows[k][COEF_W*l +: COEF_W];
          px  = longint'(taps[(k + TAP_OFF) * 3 + l + TAP_OFF]);
          acc += px * c;
        end
      end
      return acc[SUM_W-1:0];
    endfunction

    function void note_input(bit cmd, bit [PIX_W-1:0] pix);
      int unsigned   w;
      int unsigned   h;
      int unsigned   ir;
      int unsigned   ic;
      int unsigned   orow;
      int unsigned   ocol;
      bit [PIX_W-1:0] px;
      bit [PIX_W-1:0] top;
      bit [PIX_W-1:0] mid;
      bit [PIX_W-1:0] win [9];
      bit            emit;
      pixel_result_t res;
      w = clamp_dim(32'(width_reg), MAX_WIDTH);
      h = clamp_dim(32'(height_reg), MAX_HEIGHT);
      if (in_col >= w || in_row > h + 1) restart_frame();
      ir   = in_row;
      ic   = in_col;
      emit = 1'b0;
      orow = 0;
      ocol = 0;
      // Flush inside the image is a zero pixel; a pixel below the image is padding.
      px  = (cmd == CMD_PIXEL && ir < h) ? pix : '0;
      top = (ir >= 2) ? line_mem[ic] : '0;
      mid = (ir >= 1) ? line_mem[MAX_WIDTH + ic] : '0;
      // Column 0 closes out the last column of the row two above.
      if (ic == 0 && ir >= 2 && ir - 2 < h) begin
        for (int r = 0; r < 3; r++) begin
          win[r*3 + 0] = (w >= 2) ? win_regs[r*3 + 1] : '0;
          win[r*3 + 1] = win_regs[r*3 + 2];
          win[r*3 + 2] = '0;
        end
        orow = ir - 2;
        ocol = w - 1;
        emit = 1'b1;
      end
      for (int r = 0; r < 3; r++) begin
        win_regs[r*3 + 0] = win_regs[r*3 + 1];
        win_regs[r*3 + 1] = win_regs[r*3 + 2];
      end
      win_regs[2] = top;
      win_regs[5] = mid;
      win_regs[8] = px;
      line_mem[ic]             = mid;
      line_mem[MAX_WIDTH + ic] = px;
      if (ic >= 1 && ir >= 1 && ir - 1 < h) begin
        win = win_regs;
        if (ic == 1) begin
          win[0] = '0;
          win[3] = '0;
          win[6] = '0;
        end
        orow = ir - 1;
        ocol = ic - 1;
        emit = 1'b1;
      end
      ic++;
      if (ic >= w) begin
        ic = 0;
        ir++;
      end
      in_row = ir;
      in_col = ic;
      if (emit) begin
        res.value = weighted_sum(win);
        res.row   = orow[POS_W-1:0];
        res.col   = ocol[POS_W-1:0];
        res.last  = (orow == h - 1 && ocol == w - 1);
        expected_pixels.insert(expected_pixels.size(), res);
        if (res.last) restart_frame();
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic last);
      pixel_result_t want;
      pixel_result_t got;
      got.value = data[SUM_W-1:0];
      got.row   = data[SUM_W +: POS_W];
      got.col   = data[SUM_W + POS_W +: POS_W];
      got.last  = last;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: result with none due: value %0d row %0d col %0d last %0b",
                   $time, $signed(got.value), got.row, got.col, got.last);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("ERROR %0t: expected %0d r%0d c%0d l%0b, got %0d r%0d c%0d l%0b",
                   $time, $signed(want.value), want.row, want.col, want.last,
                   $signed(got.value), got.row, got.col, got.last);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst           = 1'b1;
  logic                   cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [COEF_ROW_W-1:0]  cfg_data      = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata  = '0;  // [15:0] pixel_value
  logic                   s_axis_tuser  = 1'b0; // [0] command
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [36:0] filtered_value, [46:37] out_row, [56:47] out_col, [63:57] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;   // frame_last

  conv_scoreboard sb;
  bit             steady;          // both sides run without idling
  bit             frame_open;      // last frame was cut short
  int             pause_countdown; // beats left before a full drain pause
  int             beats_sent;
  int             ready_hold;
  int unsigned    w_cur = MAX_WIDTH;
  int unsigned    h_cur = MAX_HEIGHT;

  conv2d_zero_padded_3x3 uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a beat never comes.
  initial begin
    #LIMIT_NS;
    $display("Mismatches found");
    $finish;
  end

  // Output side: check every accepted beat, then hold tready low for a random stall.
  always @(posedge clk) begin
    if (rst) begin
      ready_hold    = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tlast);
        ready_hold = steady ? 0 : $urandom_range(0, 3);
      end else if (ready_hold > 0) begin
        ready_hold--;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        ready_hold = $urandom_range(1, 3);
      end
      m_axis_tready <= (ready_hold == 0);
    end
  end

  function automatic bit [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Three taps per row; lean on the signed extremes and zero, some fully random, the rest modest gains.
  function automatic bit [COEF_ROW_W-1:0] pick_coef_row();
    bit [COEF_ROW_W-1:0] row;
    for (int l = 0; l < 3; l++) begin
      case ($urandom_range(0, 5))
        0:       row[COEF_W*l +: COEF_W] = 16'h8000;
        1:       row[COEF_W*l +: COEF_W] = 16'h7FFF;
        2:       row[COEF_W*l +: COEF_W] = '0;
        3:       row[COEF_W*l +: COEF_W] = COEF_W'($urandom_range(0, 16'hFFFF));
        default: row[COEF_W*l +: COEF_W] = COEF_W'($urandom_range(0, 16'h2000) - 16'h1000);
      endcase
    end
    return row;
  endfunction

  // Drop tvalid, wait out every due result, then let the pipeline settle.
  task automatic drain_results(int extra);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
    repeat (extra) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [COEF_ROW_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Present one beat after a random gap and hold it until accepted.
  task automatic send_beat(bit cmd, bit [PIX_W-1:0] pix);
    int gap;
    bit hold;
    gap  = steady ? 0 : $urandom_range(0, 3);
    hold = (pause_countdown == 1);
    if (pause_countdown > 0) pause_countdown--;
    if (hold) begin
      drain_results(0);
    end else if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(cmd, pix);
    beats_sent++;
  endtask

  // One frame: the image, then width+1 flush beats. Sprinkle early flushes
  // and pixels in the drain; a broken frame stops at a random beat.
  task automatic send_frame(int unsigned w, int unsigned h, bit broken);
    int unsigned total;
    int unsigned stop_at;
    bit          cmd;
    total   = w * h + w + 1;
    stop_at = broken ? $urandom_range(1, total - 1) : total;
    for (int unsigned i = 0; i < stop_at; i++) begin
      if (i < w * h) cmd = ($urandom_range(0, 31) == 0) ? CMD_FLUSH : CMD_PIXEL;
      else cmd = ($urandom_range(0, 4) == 0) ? CMD_PIXEL : CMD_FLUSH;
      send_beat(cmd, pick_pixel());
    end
    frame_open = broken;
  endtask

  task automatic run_phase(int unsigned w_raw, int unsigned h_raw, bit set_w, bit set_h,
                           bit all_coefs, int nframes, bit allow_broken);
    bit broken;
    drain_results(SETTLE_CYCLES);
    steady = ($urandom_range(0, 3) == 0);
    if (all_coefs || $urandom_range(0, 2) == 0) write_cfg(REG_COEF_TOP, pick_coef_row());
    if (all_coefs || $urandom_range(0, 2) == 0) write_cfg(REG_COEF_MID, pick_coef_row());
    if (all_coefs || $urandom_range(0, 2) == 0) write_cfg(REG_COEF_BOT, pick_coef_row());
    if (set_w) begin
      write_cfg(REG_IMAGE_WIDTH, COEF_ROW_W'(w_raw));
      w_cur = w_raw;
    end
    if (set_h) begin
      write_cfg(REG_IMAGE_HEIGHT, COEF_ROW_W'(h_raw));
      h_cur = h_raw;
    end
    if ($urandom_range(0, 15) == 0)
      write_cfg(CFG_IDX_W'(REG_SPARE + $urandom_range(0, 2)),
                COEF_ROW_W'({$urandom, $urandom}));
    pause_countdown = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 60) : 0;
    for (int f = 0; f < nframes; f++) begin
      broken = allow_broken && ($urandom_range(0, 6) == 0);
      send_frame(sb.clamp_dim(w_cur, MAX_WIDTH), sb.clamp_dim(h_cur, MAX_HEIGHT), broken);
      if (broken) break;
    end
  endtask

  initial begin
    int unsigned w_pick;
    int unsigned h_pick;
    int          start_beats;
    bit          first;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Undefined register index: must leave everything as it was.
    write_cfg(REG_SPARE, '1);

    // Zero sizes clamp to a single pixel; largest positive taps on a full-scale
    // pixel; a pixel arriving during the drain counts as padding.
    write_cfg(REG_IMAGE_WIDTH, '0);
    write_cfg(REG_IMAGE_HEIGHT, '0);
    write_cfg(REG_COEF_TOP, {3{16'h7FFF}});
    write_cfg(REG_COEF_MID, {3{16'h7FFF}});
    write_cfg(REG_COEF_BOT, {3{16'h7FFF}});
    w_cur = 0;
    h_cur = 0;
    send_beat(CMD_PIXEL, 16'hFFFF);
    send_beat(CMD_PIXEL, 16'h1234);
    send_beat(CMD_FLUSH, 16'hFFFF);
    drain_results(SETTLE_CYCLES);

    // 3x2 at the most negative taps: the largest negative sum, with an early
    // flush inside the image and a pixel inside the drain.
    write_cfg(REG_IMAGE_WIDTH, COEF_ROW_W'(3));
    write_cfg(REG_IMAGE_HEIGHT, COEF_ROW_W'(2));
    write_cfg(REG_COEF_TOP, {3{16'h8000}});
    write_cfg(REG_COEF_MID, {3{16'h8000}});
    write_cfg(REG_COEF_BOT, {3{16'h8000}});
    w_cur = 3;
    h_cur = 2;
    send_beat(CMD_PIXEL, 16'hFFFF);
    send_beat(CMD_PIXEL, 16'hFFFF);
    send_beat(CMD_FLUSH, 16'hFFFF);
    repeat (3) send_beat(CMD_PIXEL, 16'hFFFF);
    send_beat(CMD_FLUSH, 16'h0000);
    send_beat(CMD_PIXEL, 16'hABCD);
    send_beat(CMD_FLUSH, 16'hFFFF);
    send_beat(CMD_FLUSH, 16'h5555);
    drain_results(SETTLE_CYCLES);

    // 2x3 with mixed taps, one per-tap position at a time.
    write_cfg(REG_IMAGE_WIDTH, COEF_ROW_W'(2));
    write_cfg(REG_IMAGE_HEIGHT, COEF_ROW_W'(3));
    write_cfg(REG_COEF_TOP, {16'h0001, 16'hF000, 16'h1000});
    write_cfg(REG_COEF_MID, {16'hFFFF, 16'h2000, 16'h8000});
    write_cfg(REG_COEF_BOT, {16'h7FFF, 16'h0000, 16'hC001});
    w_cur = 2;
    h_cur = 3;
    send_beat(CMD_PIXEL, 16'h0000);
    send_beat(CMD_PIXEL, 16'h0001);
    send_beat(CMD_PIXEL, 16'h8000);
    send_beat(CMD_PIXEL, 16'hFFFF);
    send_beat(CMD_PIXEL, 16'h7FFF);
    send_beat(CMD_PIXEL, 16'h0001);
    repeat (3) send_beat(CMD_FLUSH, 16'h0000);

    // Start another frame, stall the sender until all results are out, then
    // leave the frame half done: the next size write must drop it.
    pause_countdown = 2;
    send_beat(CMD_PIXEL, 16'h4321);
    send_beat(CMD_PIXEL, 16'hFFFF);
    send_beat(CMD_PIXEL, 16'h0F0F);
    frame_open = 1'b1;

    // Extreme size: tallest column with over-range height on single-pixel rows.
    run_phase(1, 2047, 1'b1, 1'b1, 1'b1, 1, 1'b0);

    // Random phases: mostly whole frames of small sizes, some cut short.
    first       = 1'b1;
    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w_pick = 0;
        1:       w_pick = 1;
        2:       w_pick = 2;
        3:       w_pick = $urandom_range(9, 40);
        default: w_pick = $urandom_range(2, 8);
      endcase
      case ($urandom_range(0, 7))
        0:       h_pick = 0;
        1:       h_pick = 1;
        default: h_pick = $urandom_range(1, 5);
      endcase
      run_phase(w_pick, h_pick, frame_open || $urandom_range(0, 2) != 0,
                $urandom_range(0, 1) == 1, first, $urandom_range(1, 3), 1'b1);
      first = 1'b0;
    end

    drain_results(SETTLE_CYCLES);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
